/* design/plr_pkg.sv */
// plr_pkg: shared types, constants and sample conversion for the PCM
// linear resampler. No dependencies; used by the interfaces and the core.
package plr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int STEP_W     = 21;
  localparam int SAMPLE_W   = 16;
  localparam int RAW_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int FMT_W      = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RAW_W-1:0]           raw_t;
  typedef logic [FMT_W-1:0]           fmt_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd2;

  // sample formats
  localparam fmt_t FMT_U8   = 2'd0;
  localparam fmt_t FMT_S16  = 2'd1;
  localparam fmt_t FMT_S24  = 2'd2;
  localparam fmt_t FMT_NONE = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RESET   = 21'd65536;
  localparam fmt_t              FORMAT_RESET = FMT_S16;

  // raw little-endian bytes to signed 16-bit
  function automatic sample_t convert(raw_t raw, fmt_t fmt);
    sample_t s;
    unique case (fmt)
      FMT_U8:   s = {~raw[7], raw[6:0], 8'h00};
      FMT_S16:  s = raw[15:0];
      FMT_S24:  s = raw[23:8];
      default:  s = '0;
    endcase
    return s;
  endfunction

endpackage

/* design/plr_in_if.sv */
// plr_in_if: input frame channel (valid/ready plus raw frame fields).
// Depends on plr_pkg for field types.
interface plr_in_if;
  logic          valid;
  logic          ready;
  plr_pkg::raw_t raw_left;
  plr_pkg::raw_t raw_right;
  logic          final_frame;

  modport source(output valid, raw_left, raw_right, final_frame, input ready);
  modport sink(input valid, raw_left, raw_right, final_frame, output ready);
endinterface

/* design/plr_out_if.sv */
// plr_out_if: result channel (valid/ready plus stereo int16 pair).
// Depends on plr_pkg for field types.
interface plr_out_if;
  logic             valid;
  logic             ready;
  plr_pkg::sample_t out_left;
  plr_pkg::sample_t out_right;
  logic             run_end;

  modport source(output valid, out_left, out_right, run_end, input ready);
  modport sink(input valid, out_left, out_right, run_end, output ready);
endinterface

/* design/pcm_linear_resampler_core.sv */
// pcm_linear_resampler_core: linear-interpolation sample rate converter.
// Depends on plr_pkg, plr_in_if and plr_out_if.
//
// Usage:
//  - in_ch carries one raw PCM frame per transaction (left/right bytes,
//    final_frame). Each frame is converted to int16 per sample_format.
//  - out_ch carries stereo int16 pairs; run_end flags the last pair caused
//    by a frame. A frame may cause zero to 64 pairs.
//  - cfg_we/cfg_index/cfg_data write step_ratio, mono_mode, sample_format;
//    write only while idle. Out-of-range indexes are ignored.
// Timing:
//  - One frame at a time; in_ch.ready is high only while idle.
//  - Interpolated pairs use one shared multiplier, which runs the left then
//    the right product. Tail pairs after a final frame repeat the last
//    sample. Ready stays low while a frame's pairs are made (not for a
//    stored first frame), and on a final frame also while the tail runs.
//  - A frame's first pair passes S_LOOP, S_MULR and S_EMIT into out_ch.
// Backpressure: a one-deep output register holds a pair until taken; the
//  sequencer waits while it is full and out_ch.ready is low.
// Reset (rst_n, synchronous): config returns to step 1.0, stereo, 16-bit;
//  held sample, phase and output valid clear. After a final frame the
//  held sample and phase clear as well, config is kept.
module pcm_linear_resampler_core #(
  parameter int FRAC_BITS = plr_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  plr_in_if.sink                          in_ch,
  plr_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [plr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int STEP_W = plr_pkg::STEP_W;
  localparam int SMP_W  = plr_pkg::SAMPLE_W;
  // phase stays below one frame plus one step
  localparam int PH_W   = ((FRAC_BITS > STEP_W) ? FRAC_BITS : STEP_W) + 1;
  localparam int DIFF_W = SMP_W + 1;
  localparam int NUM_W  = FRAC_BITS + DIFF_W + 1;

  localparam logic [PH_W-1:0]   ONE_POS  = PH_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_BITS - 5);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOP  = 3'd1;  // phase check / frame wrap-up
  localparam logic [2:0] S_MULR  = 3'd2;  // left done, right product
  localparam logic [2:0] S_EMIT  = 3'd3;  // load pair into output reg
  localparam logic [2:0] S_TAIL  = 3'd4;  // repeat last sample

  logic [2:0]               state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     mono_r, mono_nxt;
  plr_pkg::fmt_t            fmt_r, fmt_nxt;

  plr_pkg::sample_t         prev_left_r, prev_left_nxt;
  plr_pkg::sample_t         prev_right_r, prev_right_nxt;
  plr_pkg::sample_t         cur_left_r, cur_left_nxt;
  plr_pkg::sample_t         cur_right_r, cur_right_nxt;
  logic                     fin_r, fin_nxt;
  logic                     have_prev_r, have_prev_nxt;
  logic [PH_W-1:0]          phase_r, phase_nxt;
  logic signed [NUM_W-1:0]  mul_r, mul_nxt;
  plr_pkg::sample_t         left_res_r, left_res_nxt;

  logic                     out_valid_r, out_valid_nxt;
  plr_pkg::sample_t         out_left_r, out_left_nxt;
  plr_pkg::sample_t         out_right_r, out_right_nxt;
  logic                     out_end_r, out_end_nxt;

  plr_pkg::sample_t         conv_left, conv_right;
  logic [STEP_W-1:0]        step_eff;
  logic [PH_W-1:0]          next_phase, next_wrapped;
  logic                     np_ge_one, np_ge_two;
  logic                     out_free;

  // shared multiplier
  logic [FRAC_BITS-1:0]     mul_frac;
  logic signed [DIFF_W-1:0] mul_diff;
  logic signed [DIFF_W-1:0] diff_left, diff_right;
  logic signed [NUM_W-1:0]  mul_prod;
  logic                     mul_en;

  // shared lerp finisher: s0 + prod / 2^FRAC, truncated toward zero
  plr_pkg::sample_t         fin_s0;
  logic signed [NUM_W-1:0]  fin_num, fin_q;
  plr_pkg::sample_t         lerp_q;

  assign conv_left  = plr_pkg::convert(in_ch.raw_left, fmt_r);
  assign conv_right = mono_r ? conv_left : plr_pkg::convert(in_ch.raw_right, fmt_r);

  assign step_eff     = (step_r < MIN_STEP) ? MIN_STEP : step_r;
  assign next_phase   = phase_r + PH_W'(step_eff);
  assign np_ge_one    = (next_phase >= ONE_POS);
  assign next_wrapped = next_phase - ONE_POS;
  assign np_ge_two    = np_ge_one && (next_wrapped >= ONE_POS);

  assign diff_left  = DIFF_W'(cur_left_r) - DIFF_W'(prev_left_r);
  assign diff_right = DIFF_W'(cur_right_r) - DIFF_W'(prev_right_r);
  assign mul_prod   = NUM_W'($signed({1'b0, mul_frac})) * NUM_W'(mul_diff);
  assign mul_nxt    = mul_en ? mul_prod : mul_r;

  assign fin_s0  = (state_r == S_MULR) ? prev_left_r : prev_right_r;
  assign fin_num = (NUM_W'(fin_s0) <<< FRAC_BITS) + mul_r;
  always_comb begin
    fin_q = fin_num >>> FRAC_BITS;
    if (fin_num[NUM_W-1] && (|fin_num[FRAC_BITS-1:0])) begin
      fin_q = fin_q + NUM_W'(1);
    end
    lerp_q = fin_q[SMP_W-1:0];
  end

  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_left_r;
  assign out_ch.out_right = out_right_r;
  assign out_ch.run_end   = out_end_r;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    mono_nxt       = mono_r;
    fmt_nxt        = fmt_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    fin_nxt        = fin_r;
    have_prev_nxt  = have_prev_r;
    phase_nxt      = phase_r;
    left_res_nxt   = left_res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_end_nxt    = out_end_r;
    mul_en         = 1'b0;
    mul_frac       = phase_r[FRAC_BITS-1:0];
    mul_diff       = diff_left;

    if (cfg_we) begin
      unique case (cfg_index)
        plr_pkg::CFG_STEP_RATIO:    step_nxt = cfg_data[STEP_W-1:0];
        plr_pkg::CFG_MONO_MODE:     mono_nxt = cfg_data[0];
        plr_pkg::CFG_SAMPLE_FORMAT: fmt_nxt  = cfg_data[plr_pkg::FMT_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_left_nxt  = conv_left;
          cur_right_nxt = conv_right;
          fin_nxt       = in_ch.final_frame;
          if (have_prev_r) begin
            state_nxt = S_LOOP;
          end else begin
            // first frame is only stored
            prev_left_nxt  = conv_left;
            prev_right_nxt = conv_right;
            have_prev_nxt  = 1'b1;
            state_nxt      = in_ch.final_frame ? S_TAIL : S_IDLE;
          end
        end
      end
      S_LOOP: begin
        if (phase_r < ONE_POS) begin
          mul_en    = 1'b1;
          state_nxt = S_MULR;
        end else begin
          phase_nxt      = phase_r - ONE_POS;
          prev_left_nxt  = cur_left_r;
          prev_right_nxt = cur_right_r;
          have_prev_nxt  = 1'b1;
          state_nxt      = fin_r ? S_TAIL : S_IDLE;
        end
      end
      S_MULR: begin
        left_res_nxt = lerp_q;
        mul_en       = 1'b1;
        mul_diff     = diff_right;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = left_res_r;
          out_right_nxt = lerp_q;
          // last pair unless the tail will still emit
          out_end_nxt   = np_ge_one && (!fin_r || np_ge_two);
          phase_nxt     = next_phase;
          if (!np_ge_one) begin
            // start next left product right away
            mul_en    = 1'b1;
            mul_frac  = next_phase[FRAC_BITS-1:0];
            state_nxt = S_MULR;
          end else begin
            state_nxt = S_LOOP;
          end
        end
      end
      S_TAIL: begin
        if (phase_r < ONE_POS) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_left_nxt  = cur_left_r;
            out_right_nxt = cur_right_r;
            out_end_nxt   = np_ge_one;
            phase_nxt     = next_phase;
          end
        end else begin
          prev_left_nxt  = '0;
          prev_right_nxt = '0;
          phase_nxt      = '0;
          have_prev_nxt  = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= plr_pkg::STEP_RESET;
      mono_r       <= 1'b0;
      fmt_r        <= plr_pkg::FORMAT_RESET;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      have_prev_r  <= 1'b0;
      phase_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      mono_r       <= mono_nxt;
      fmt_r        <= fmt_nxt;
      prev_left_r  <= prev_left_nxt;
      prev_right_r <= prev_right_nxt;
      have_prev_r  <= have_prev_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_left_r  <= cur_left_nxt;
    cur_right_r <= cur_right_nxt;
    fin_r       <= fin_nxt;
    mul_r       <= mul_nxt;
    left_res_r  <= left_res_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule
